// ----- rtl/dcwq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcwq_pkg
// Shared types and codes for the dual-class work queue.
// ----------------------------------------------------------------------------
package dcwq_pkg;

  // request kinds
  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindTake  = 2'd1;
  localparam logic [1:0] KindPeek  = 2'd2;
  localparam logic [1:0] KindFlush = 2'd3;

  // result status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatEmpty   = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;
  localparam logic [1:0] StatDiscard = 2'd3;

  // register indexes
  localparam logic CfgMinMerge = 1'b0;
  localparam logic CfgSlotSize = 1'b1;

  localparam int BaseW    = 48;
  localparam int LenInW   = 31;
  localparam int LenW     = 32;
  localparam int OffW     = 31;
  localparam int VolW     = 48;
  localparam int SlotW    = 4;
  localparam int AddrBits = 48;

  // address wrap for contiguity check
  localparam int EndW     = BaseW + 1;
  localparam int EndBits  = (AddrBits < EndW) ? AddrBits : EndW;
  localparam int BaseBits = (AddrBits < BaseW) ? AddrBits : BaseW;
  localparam logic [EndW-1:0]  EndMask  = {EndW{1'b1}} >> (EndW - EndBits);
  localparam logic [BaseW-1:0] BaseMask = {BaseW{1'b1}} >> (BaseW - BaseBits);

  localparam logic [LenInW-1:0] MinMergeRst = LenInW'(4096);
  localparam logic [SlotW-1:0]  SlotRst     = SlotW'(8);

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic [LenW-1:0]  len;
    logic [OffW-1:0]  off;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/dual_class_work_queue_coalescing_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_class_work_queue_coalescing_unit
// Two FIFO classes of work ranges with tail merging and a running volume.
// ----------------------------------------------------------------------------
// One request per cycle is sustained while out_ready stays high. A request is
// registered on accept and its result lands in the output register when the
// request fires; the output register lets a new request in while a result
// still waits. Each class keeps its head and tail entries in registers and
// holds the rest in a QUEUE_DEPTH x 111-bit memory with one write port and
// one registered read port; that read port fetches the entry behind the head
// every cycle, which is what lets a take follow a take with no gap. There is
// no clearing pass after reset.
module dual_class_work_queue_coalescing_unit
  import dcwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [LenInW-1:0] cfg_data,
  // requests
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_kind,
  input  wire logic              in_prefer_deferred,
  input  wire logic [BaseW-1:0]  in_range_base,
  input  wire logic [LenInW-1:0] in_range_length,
  input  wire logic [OffW-1:0]   in_range_offset,
  // results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [BaseW-1:0]       out_base,
  output logic [LenW-1:0]        out_length,
  output logic [OffW-1:0]        out_offset,
  output logic                   out_from_deferred,
  output logic [VolW-1:0]        out_total_volume
);

  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(QUEUE_DEPTH - 1);

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    ring_next = (idx == IdxLast) ? '0 : idx + 1'b1;
  endfunction

  // configuration registers
  logic [LenInW-1:0] min_merge_r;
  logic [SlotW-1:0]  slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_merge_r <= MinMergeRst;
      slot_r      <= SlotRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgMinMerge: min_merge_r <= cfg_data;
        CfgSlotSize: slot_r      <= cfg_data[SlotW-1:0];
        default:     ;
      endcase
    end
  end

  // input register
  logic              req_valid_r;
  logic [1:0]        kind_r;
  logic              pref_r;
  logic [BaseW-1:0]  base_r;
  logic [LenInW-1:0] len_r;
  logic [OffW-1:0]   off_r;
  logic              fire;
  logic              out_valid_r;

  assign fire     = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      pref_r <= in_prefer_deferred;
      base_r <= in_range_base;
      len_r  <= in_range_length;
      off_r  <= in_range_offset;
    end
  end

  // per-class state
  logic [CntW-1:0] cnt_r      [2];
  logic [IdxW-1:0] head_r     [2];
  logic [IdxW-1:0] tail_r     [2];
  entry_t          head_ent_r [2];
  entry_t          tail_ent_r [2];
  entry_t          nh_r       [2];
  logic [VolW-1:0] vol_r;

  // shared decode
  logic             empty0, empty1, sel, tgt;
  logic             is_add, is_look, is_flush;
  logic [BaseW-1:0] nr_base;
  entry_t           nr_ent, tent, hent;
  logic [EndW-1:0]  tail_end;
  logic             can_merge, tfull;
  logic             merge, append, drop, hit, pop;
  logic [LenW-1:0]  mul_len;
  logic             mul_off_nz;
  logic [LenW+SlotW-1:0] prod;
  logic [VolW-1:0]  range_vol, vol_nxt;

  always_comb begin
    empty0   = (cnt_r[0] == '0);
    empty1   = (cnt_r[1] == '0);
    tgt      = pref_r;
    // preferred class, else the other one
    sel      = pref_r ? !empty1 : empty0;
    is_add   = fire && (kind_r == KindAdd) && (len_r != '0);
    is_look  = fire && ((kind_r == KindTake) || (kind_r == KindPeek));
    is_flush = fire && (kind_r == KindFlush);

    nr_base  = base_r & BaseMask;
    nr_ent   = '{base: nr_base, len: {1'b0, len_r}, off: off_r};
    tent     = tail_ent_r[tgt];
    hent     = head_ent_r[sel];

    tail_end  = ({1'b0, tent.base} + {{(EndW-LenW){1'b0}}, tent.len}) & EndMask;
    can_merge = (cnt_r[tgt] != '0) && (tent.len < {1'b0, min_merge_r}) &&
                ({1'b0, nr_base} == tail_end) && (off_r == '0) && (tent.off == '0);
    tfull     = (cnt_r[tgt] == CntFull);

    merge  = is_add && can_merge;
    append = is_add && !can_merge && !tfull;
    drop   = is_add && !can_merge && tfull;
    hit    = is_look && !(empty0 && empty1);
    pop    = hit && (kind_r == KindTake);

    // one multiplier serves both the added range and the removed head
    mul_len    = (kind_r == KindAdd) ? {1'b0, len_r} : hent.len;
    mul_off_nz = (kind_r == KindAdd) ? (off_r != '0) : (hent.off != '0);
    prod       = {{SlotW{1'b0}}, mul_len} * {{LenW{1'b0}}, slot_r};
    range_vol  = mul_off_nz ? VolW'(prod) : VolW'(mul_len);

    vol_nxt = vol_r;
    priority if (is_flush) begin
      vol_nxt = '0;
    end else if (merge || append) begin
      vol_nxt = vol_r + range_vol;
    end else if (pop) begin
      vol_nxt = vol_r - range_vol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r <= '0;
    end else begin
      vol_r <= vol_nxt;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_cls
    entry_t          mem [QUEUE_DEPTH];
    logic            ap, mg, pp;
    logic [CntW-1:0] cnt_nxt;
    logic [IdxW-1:0] head_nxt, tail_nxt;
    entry_t          head_ent_nxt, tail_ent_nxt, merged;

    always_comb begin
      ap = append && (tgt == c[0]);
      mg = merge && (tgt == c[0]);
      pp = pop && (sel == c[0]);
      merged     = tail_ent_r[c];
      merged.len = tail_ent_r[c].len + {1'b0, len_r};

      cnt_nxt  = cnt_r[c];
      head_nxt = head_r[c];
      tail_nxt = tail_r[c];
      tail_ent_nxt = tail_ent_r[c];
      priority if (is_flush) begin
        cnt_nxt  = '0;
        head_nxt = '0;
        tail_nxt = '0;
      end else if (ap) begin
        cnt_nxt      = cnt_r[c] + 1'b1;
        tail_ent_nxt = nr_ent;
        if (cnt_r[c] == '0) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          tail_nxt = ring_next(tail_r[c]);
        end
      end else if (mg) begin
        tail_ent_nxt = merged;
      end else if (pp) begin
        cnt_nxt = cnt_r[c] - 1'b1;
        if (cnt_r[c] == CntW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          head_nxt = ring_next(head_r[c]);
        end
      end

      // head copy: single entry mirrors the tail, else the prefetched next on a pop
      if (cnt_nxt == CntW'(1)) begin
        head_ent_nxt = tail_ent_nxt;
      end else if (pp) begin
        head_ent_nxt = nh_r[c];
      end else begin
        head_ent_nxt = head_ent_r[c];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[c]  <= '0;
        head_r[c] <= '0;
        tail_r[c] <= '0;
      end else begin
        cnt_r[c]  <= cnt_nxt;
        head_r[c] <= head_nxt;
        tail_r[c] <= tail_nxt;
      end
    end

    always_ff @(posedge clk) begin
      head_ent_r[c] <= head_ent_nxt;
      tail_ent_r[c] <= tail_ent_nxt;
    end

    always_ff @(posedge clk) begin
      if (ap || mg) begin
        mem[tail_nxt] <= tail_ent_nxt;
      end
      nh_r[c] <= mem[ring_next(head_nxt)];
    end
  end

  // result register
  logic [1:0]       status_r;
  logic [BaseW-1:0] obase_r;
  logic [LenW-1:0]  olen_r;
  logic [OffW-1:0]  ooff_r;
  logic             odef_r;
  logic [VolW-1:0]  ovol_r;
  logic [1:0]       status_nxt;

  always_comb begin
    status_nxt = StatOk;
    priority if (fire && (kind_r == KindAdd) && (len_r == '0)) begin
      status_nxt = StatDiscard;
    end else if (drop) begin
      status_nxt = StatFull;
    end else if (is_look && !hit) begin
      status_nxt = StatEmpty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      obase_r  <= hit ? hent.base : '0;
      olen_r   <= hit ? hent.len : '0;
      ooff_r   <= hit ? hent.off : '0;
      odef_r   <= hit && sel;
      ovol_r   <= vol_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_base          = obase_r;
  assign out_length        = olen_r;
  assign out_offset        = ooff_r;
  assign out_from_deferred = odef_r;
  assign out_total_volume  = ovol_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CntFull) && (cnt_r[1] <= CntFull))
    else $error("class count above depth");

  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r[0] == '0) |-> (head_r[0] == '0) && (tail_r[0] == '0)) and
    ((cnt_r[1] == '0) |-> (head_r[1] == '0) && (tail_r[1] == '0)))
    else $error("empty class with nonzero ring index");

  a_head_len: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (hent.len != '0))
    else $error("queued head range has zero length");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != StatOk)) |-> (olen_r == '0) && !odef_r)
    else $error("non-ok result carries a range");
`endif

endmodule
`default_nettype wire
